/* rtl/pmgs_pkg.sv */
// shared constants, types and the ring reciprocal table of the polar mesh gradient store
`timescale 1ns / 1ps

package pmgs_pkg;

  localparam int MAX_RINGS_DEF   = 64;
  localparam int MAX_SECTORS_DEF = 128;
  localparam int VALUE_WIDTH     = 32;

  localparam int ACTION_W    = 2;
  localparam int RING_IDX_W  = 6;
  localparam int SECT_IDX_W  = 7;
  localparam int RCNT_W      = 7;
  localparam int PCNT_W      = 8;
  localparam int SCALE_W     = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int CNT_W       = 11;
  localparam int MIN_COUNT   = 2;

  localparam int RECIP_W   = 18;
  localparam int ROM_DEPTH = 64;

  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_GRAD  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_RADIAL_COUNT      = 2'd0,
    REG_POLAR_COUNT       = 2'd1,
    REG_INV_TWO_DR        = 2'd2,
    REG_INV_TWO_DTHETA_DR = 2'd3
  } cfg_reg_t;

  // one step enable per stage of the gradient datapath
  typedef struct packed {
    logic rad_diff;
    logic ang_diff;
    logic rad_mul;
    logic ang_mul;
    logic ang_clamp;
    logic ang_recip;
    logic ang_round;
  } grad_ctl_t;

  // 1/(i+0.5) in unsigned Q2.16, nearest
  localparam logic [RECIP_W-1:0] RECIP_ROM [ROM_DEPTH] = '{
    131072, 43691, 26214, 18725, 14564, 11916, 10082, 8738,
    7710,   6899,  6242,  5699,  5243,  4855,  4520,  4228,
    3972,   3745,  3542,  3361,  3197,  3048,  2913,  2789,
    2675,   2570,  2473,  2383,  2300,  2222,  2149,  2081,
    2016,   1956,  1900,  1846,  1796,  1748,  1702,  1659,
    1618,   1579,  1542,  1507,  1473,  1440,  1409,  1380,
    1351,   1324,  1298,  1273,  1248,  1225,  1202,  1181,
    1160,   1140,  1120,  1101,  1083,  1066,  1049,  1032
  };

endpackage

/* rtl/pmgs_ifs.sv */
// valid/ready channel interfaces for mesh items and results
`timescale 1ns / 1ps

interface pmgs_item_if;
  import pmgs_pkg::*;
  logic                          valid;
  logic                          ready;
  logic [ACTION_W-1:0]           action;
  logic [RING_IDX_W-1:0]         ring_index;
  logic [SECT_IDX_W-1:0]         sector_index;
  logic signed [VALUE_WIDTH-1:0] write_value;

  modport source (output valid, action, ring_index, sector_index, write_value, input ready);
  modport sink   (input valid, action, ring_index, sector_index, write_value, output ready);
endinterface

interface pmgs_result_if;
  import pmgs_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] read_value;
  logic signed [VALUE_WIDTH-1:0] grad_radial;
  logic signed [VALUE_WIDTH-1:0] grad_angular;
  logic                          status;

  modport source (output valid, read_value, grad_radial, grad_angular, status, input ready);
  modport sink   (input valid, read_value, grad_radial, grad_angular, status, output ready);
endinterface

/* rtl/pmgs_ram.sv */
// generic ram, one write port and two registered read ports
`timescale 1ns / 1ps

module pmgs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* rtl/pmgs_grad.sv */
// difference, scaling, rounding and saturation stages of the gradient
`timescale 1ns / 1ps

module pmgs_grad import pmgs_pkg::*; (
  input  logic                   clk,
  input  grad_ctl_t              ctl,
  input  logic                   one_sided,
  input  logic [VALUE_WIDTH-1:0] rd_a,
  input  logic [VALUE_WIDTH-1:0] rd_b,
  input  logic [SCALE_W-1:0]     inv_two_dr,
  input  logic [SCALE_W-1:0]     inv_two_dtheta_dr,
  input  logic [RECIP_W-1:0]     recip,
  output logic [VALUE_WIDTH-1:0] grad_radial,
  output logic [VALUE_WIDTH-1:0] grad_angular
);

  localparam int DW     = VALUE_WIDTH;
  localparam int PROD_W = DW + SCALE_W;
  localparam int RND_W  = PROD_W - 14;
  localparam int T_W    = 47;
  localparam int P2_W   = T_W + RECIP_W;
  localparam logic [T_W-1:0] T_CAP = {1'b1, {(T_W-1){1'b0}}};

  function automatic logic [DW-1:0] sat(input logic neg, input logic [RND_W-1:0] mag);
    logic [DW-1:0] res;
    if (neg) begin
      if (mag >= RND_W'({1'b1, {(DW-1){1'b0}}})) res = {1'b1, {(DW-1){1'b0}}};
      else res = '0 - mag[DW-1:0];
    end else begin
      if (mag >= RND_W'({1'b0, {(DW-1){1'b1}}})) res = {1'b0, {(DW-1){1'b1}}};
      else res = mag[DW-1:0];
    end
    return res;
  endfunction

  logic [DW:0]       d_ab, d_ba;
  logic              d_neg;
  logic [DW-1:0]     d_mag;
  logic              rad_neg, ang_neg;
  logic [DW-1:0]     rad_mag, ang_mag;
  logic [PROD_W-1:0] prod_r, prod_a;
  logic [RND_W-1:0]  r15, r16, r_t, rad_rnd, ang_rnd, r_p2;
  logic [T_W-1:0]    t;
  logic [P2_W-1:0]   prod2;

  // both differences in parallel, sign of a-b picks the magnitude
  assign d_ab  = {rd_a[DW-1], rd_a} - {rd_b[DW-1], rd_b};
  assign d_ba  = {rd_b[DW-1], rd_b} - {rd_a[DW-1], rd_a};
  assign d_neg = d_ab[DW];
  assign d_mag = d_neg ? d_ba[DW-1:0] : d_ab[DW-1:0];

  assign r15  = RND_W'(({1'b0, prod_r} + (PROD_W+1)'(1 << 14)) >> 15);
  assign r16  = RND_W'(({1'b0, prod_r} + (PROD_W+1)'(1 << 15)) >> 16);
  assign r_t  = RND_W'(({1'b0, prod_a} + (PROD_W+1)'(1 << 15)) >> 16);
  assign r_p2 = RND_W'(({1'b0, prod2} + (P2_W+1)'(1 << 15)) >> 16);

  always_ff @(posedge clk) begin
    if (ctl.rad_diff) begin
      rad_neg <= d_neg;
      rad_mag <= d_mag;
    end
    if (ctl.ang_diff) begin
      ang_neg <= d_neg;
      ang_mag <= d_mag;
    end
    if (ctl.rad_mul) begin
      prod_r <= PROD_W'(rad_mag) * PROD_W'(inv_two_dr);
    end
    if (ctl.ang_mul) begin
      prod_a  <= PROD_W'(ang_mag) * PROD_W'(inv_two_dtheta_dr);
      rad_rnd <= one_sided ? r15 : r16;
    end
    if (ctl.ang_clamp) begin
      t           <= (r_t > RND_W'(T_CAP)) ? T_CAP : r_t[T_W-1:0];
      grad_radial <= sat(rad_neg, rad_rnd);
    end
    if (ctl.ang_recip) begin
      prod2 <= P2_W'(t) * P2_W'(recip);
    end
    if (ctl.ang_round) begin
      ang_rnd <= r_p2;
    end
  end

  assign grad_angular = sat(ang_neg, ang_rnd);

endmodule

/* rtl/polar_mesh_gradient_store_core.sv */
// polar mesh value store with radial and angular central-difference gradients
// write, action 3 or bad index finish in the idle state, a read in S_READ and a gradient in S_FIN
// a write every cycle while the output is free; a read or gradient holds off new items
// the gradient does radial then angular reads of the dual-read mesh ram and a scale chain
// rst (synchronous) restores registers to 64 rings, 128 sectors and unit scales
// the mesh ram is not cleared; cells hold garbage until written
`timescale 1ns / 1ps

module polar_mesh_gradient_store_core import pmgs_pkg::*; #(
  parameter int MAX_RINGS   = MAX_RINGS_DEF,
  parameter int MAX_SECTORS = MAX_SECTORS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  pmgs_item_if.sink              item,
  pmgs_result_if.source          result,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int DEPTH  = MAX_RINGS * MAX_SECTORS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int RING_W = $clog2(MAX_RINGS);
  localparam int SECT_W = $clog2(MAX_SECTORS);
  localparam int DW     = VALUE_WIDTH;

  typedef struct packed {
    logic [DW-1:0] read_value;
    logic [DW-1:0] grad_radial;
    logic [DW-1:0] grad_angular;
    logic          status;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_RAD, S_ANG, S_MUL, S_CLAMP, S_RECIP, S_ROUND, S_FIN, S_PUSH
  } state_t;

  // row-major cell address, ring times MAX_SECTORS plus sector
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [CNT_W-1:0] r,
                                                  input logic [CNT_W-1:0] s);
    return ADDR_W'(r[RING_W-1:0]) * ADDR_W'(MAX_SECTORS) + ADDR_W'(s[SECT_W-1:0]);
  endfunction

  // configuration registers
  logic [RCNT_W-1:0]  radial_count;
  logic [PCNT_W-1:0]  polar_count;
  logic [SCALE_W-1:0] inv_two_dr;
  logic [SCALE_W-1:0] inv_two_dtheta_dr;

  state_t         state;
  logic           out_valid;
  result_t        out_word, res_word, fin_word;
  logic           fin_now;
  logic           out_free;

  // captured item
  logic [CNT_W-1:0] ring_r, sect_r;
  logic             one_sided_r;

  // item decode
  action_t          act;
  logic             accept;
  logic [CNT_W-1:0] ring_ext, sect_ext, rcnt, pcnt, rc_eff, pc_eff;
  logic             index_ok;
  logic [CNT_W-1:0] ra_ring, rb_ring;
  logic             one_sided;
  logic [CNT_W-1:0] sect_next, sect_prev;

  // ram ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr_a, ram_raddr_b;
  logic [DW-1:0]     ram_rdata_a, ram_rdata_b;

  grad_ctl_t     gctl;
  logic [DW-1:0] grad_radial, grad_angular;

  always_ff @(posedge clk) begin
    if (rst) begin
      radial_count      <= RCNT_W'(MAX_RINGS_DEF);
      polar_count       <= PCNT_W'(MAX_SECTORS_DEF);
      inv_two_dr        <= SCALE_W'(65536);
      inv_two_dtheta_dr <= SCALE_W'(65536);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_RADIAL_COUNT:      radial_count      <= cfg_data[RCNT_W-1:0];
        REG_POLAR_COUNT:       polar_count       <= cfg_data[PCNT_W-1:0];
        REG_INV_TWO_DR:        inv_two_dr        <= cfg_data[SCALE_W-1:0];
        REG_INV_TWO_DTHETA_DR: inv_two_dtheta_dr <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // counts limited to 2..max
  always_comb begin
    rcnt = CNT_W'(radial_count);
    pcnt = CNT_W'(polar_count);
    if (rcnt < CNT_W'(MIN_COUNT)) rc_eff = CNT_W'(MIN_COUNT);
    else if (rcnt > CNT_W'(MAX_RINGS)) rc_eff = CNT_W'(MAX_RINGS);
    else rc_eff = rcnt;
    if (pcnt < CNT_W'(MIN_COUNT)) pc_eff = CNT_W'(MIN_COUNT);
    else if (pcnt > CNT_W'(MAX_SECTORS)) pc_eff = CNT_W'(MAX_SECTORS);
    else pc_eff = pcnt;
  end

  // no word is taken while reset is held
  assign act      = action_t'(item.action);
  assign ring_ext = CNT_W'(item.ring_index);
  assign sect_ext = CNT_W'(item.sector_index);
  assign index_ok = (ring_ext < rc_eff) && (sect_ext < pc_eff);
  assign item.ready = (state == S_IDLE) && !rst;
  assign accept   = item.valid && item.ready;

  // radial neighbours: one-sided at the inner and outer ring, a read uses port a alone
  always_comb begin
    ra_ring   = ring_ext + CNT_W'(1);
    rb_ring   = ring_ext - CNT_W'(1);
    one_sided = 1'b0;
    if (act == ACT_READ) begin
      ra_ring = ring_ext;
    end else if (ring_ext == '0) begin
      ra_ring   = CNT_W'(1);
      rb_ring   = '0;
      one_sided = 1'b1;
    end else if (ring_ext == rc_eff - CNT_W'(1)) begin
      ra_ring   = ring_ext;
      one_sided = 1'b1;
    end
  end

  // angular neighbours wrap over the sectors in use
  assign sect_next = (sect_r + CNT_W'(1) == pc_eff) ? '0 : sect_r + CNT_W'(1);
  assign sect_prev = (sect_r == '0) ? pc_eff - CNT_W'(1) : sect_r - CNT_W'(1);

  assign ram_we      = accept && (act == ACT_WRITE) && index_ok;
  assign ram_waddr   = cell_addr(ring_ext, sect_ext);
  assign ram_raddr_a = (state == S_IDLE) ? cell_addr(ra_ring, sect_ext)
                                         : cell_addr(ring_r, sect_next);
  assign ram_raddr_b = (state == S_IDLE) ? cell_addr(rb_ring, sect_ext)
                                         : cell_addr(ring_r, sect_prev);

  pmgs_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_mesh_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (item.write_value),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  // gradient step enables follow the sequencer state
  always_comb begin
    gctl           = '0;
    gctl.rad_diff  = (state == S_RAD);
    gctl.ang_diff  = (state == S_ANG);
    gctl.rad_mul   = (state == S_ANG);
    gctl.ang_mul   = (state == S_MUL);
    gctl.ang_clamp = (state == S_CLAMP);
    gctl.ang_recip = (state == S_RECIP);
    gctl.ang_round = (state == S_ROUND);
  end

  pmgs_grad u_grad (
    .clk               (clk),
    .ctl               (gctl),
    .one_sided         (one_sided_r),
    .rd_a              (ram_rdata_a),
    .rd_b              (ram_rdata_b),
    .inv_two_dr        (inv_two_dr),
    .inv_two_dtheta_dr (inv_two_dtheta_dr),
    .recip             (RECIP_ROM[ring_r[RING_IDX_W-1:0]]),
    .grad_radial       (grad_radial),
    .grad_angular      (grad_angular)
  );

  // finished result word of the current state
  always_comb begin
    fin_word = '0;
    fin_now  = 1'b0;
    case (state)
      S_IDLE: begin
        fin_now = accept && !(index_ok && (act == ACT_READ || act == ACT_GRAD));
        fin_word.status = (act != ACT_NONE) && !index_ok;
      end
      S_READ: begin
        fin_now = 1'b1;
        fin_word.read_value = ram_rdata_a;
      end
      S_FIN: begin
        fin_now = 1'b1;
        fin_word.grad_radial  = grad_radial;
        fin_word.grad_angular = grad_angular;
      end
      default: ;
    endcase
  end

  // output register parts the result side from the item side
  assign out_free = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            ring_r      <= ring_ext;
            sect_r      <= sect_ext;
            one_sided_r <= one_sided;
            if (index_ok && act == ACT_READ) state <= S_READ;
            else if (index_ok && act == ACT_GRAD) state <= S_RAD;
          end
        end
        S_RAD:   state <= S_ANG;
        S_ANG:   state <= S_MUL;
        S_MUL:   state <= S_CLAMP;
        S_CLAMP: state <= S_RECIP;
        S_RECIP: state <= S_ROUND;
        S_ROUND: state <= S_FIN;
        S_READ, S_FIN: begin
        end
        S_PUSH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // a finished word goes out now, or waits in the hold register
      if (fin_now) begin
        if (out_free) begin
          state <= S_IDLE;
        end else begin
          res_word <= fin_word;
          state    <= S_PUSH;
        end
      end
      // output register load, or drop once the word is taken
      if (fin_now && out_free) begin
        out_valid <= 1'b1;
        out_word  <= fin_word;
      end else if (state == S_PUSH && out_free) begin
        out_valid <= 1'b1;
        out_word  <= res_word;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result.valid        = out_valid;
  assign result.read_value   = out_word.read_value;
  assign result.grad_radial  = out_word.grad_radial;
  assign result.grad_angular = out_word.grad_angular;
  assign result.status       = out_word.status;

endmodule

/* rtl/pmgs_checker.sv */
// port-level checks of the polar mesh gradient store, bound to the top level
`timescale 1ns / 1ps

module pmgs_checker import pmgs_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   item_valid,
  input logic                   item_ready,
  input logic [ACTION_W-1:0]    item_action,
  input logic                   result_valid,
  input logic                   result_ready,
  input logic [VALUE_WIDTH-1:0] read_value,
  input logic [VALUE_WIDTH-1:0] grad_radial,
  input logic [VALUE_WIDTH-1:0] grad_angular,
  input logic                   status
);

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result word dropped while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      $stable(read_value) && $stable(grad_radial) && $stable(grad_angular) && $stable(status))
    else $error("result payload changed while stalled");

  a_bad_index_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && status |-> read_value == '0 && grad_radial == '0 && grad_angular == '0)
    else $error("out-of-range word carries data");

  a_read_grad_excl: assert property (@(posedge clk) disable iff (rst)
    result_valid && read_value != '0 |-> grad_radial == '0 && grad_angular == '0)
    else $error("read word and gradient word mixed");

  a_write_word: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item_action == ACT_WRITE && !result_valid |=>
      result_valid && read_value == '0 && grad_radial == '0 && grad_angular == '0)
    else $error("write did not return its word in the next cycle");

endmodule

bind polar_mesh_gradient_store_core pmgs_checker u_pmgs_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .item_action  (item.action),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .read_value   (result.read_value),
  .grad_radial  (result.grad_radial),
  .grad_angular (result.grad_angular),
  .status       (result.status)
);
